FILE: hw/rtl/qvr_pkg.sv
// qvr_pkg: shared types and constants for the quaternion vector rotator
// request and result payload structs, field widths and fixed-point formats
// no dependencies
package qvr_pkg;

  // vector components are signed integers of this width
  localparam int VectorWidth  = 16;
  // quaternion components are signed Q1.14 in this width
  localparam int QuatWidth    = 16;
  localparam int QuatFracBits = 14;

  typedef struct packed {
    logic                          kind;
    logic signed [VectorWidth-1:0] vec_x;
    logic signed [VectorWidth-1:0] vec_y;
    logic signed [VectorWidth-1:0] vec_z;
    logic signed [QuatWidth-1:0]   quat_r;
    logic signed [QuatWidth-1:0]   quat_i;
    logic signed [QuatWidth-1:0]   quat_j;
    logic signed [QuatWidth-1:0]   quat_k;
  } request_t;

  typedef struct packed {
    logic signed [VectorWidth-1:0] rot_x;
    logic signed [VectorWidth-1:0] rot_y;
    logic signed [VectorWidth-1:0] rot_z;
    logic                          saturated;
  } result_t;

endpackage

FILE: hw/rtl/quaternion_vector_rotate_top.sv
// quaternion_vector_rotate_top: rotates a 3-vector by a quaternion or its conjugate
// six-stage pipelined multiplier datapath, uses qvr_pkg
//
//   channel   ports            handshake
//   -------   --------------   ---------------------------------------------
//   request   start, req       taken at a rising edge with start high, busy low
//   result    done, result     done high for one cycle per request
//
// done and result both come from the output register at the end of the stages
// listed below, and the result is valid while done is high
// a new request is taken every cycle; busy stays low
// the stages: conjugate, quaternion products, matrix terms, matrix-vector
// products, sum with rounding, saturation into the output register
// rst (synchronous) clears only the stage valid bits; the receiver cannot stall
module quaternion_vector_rotate_top #(
  parameter int QUAT_FRAC_BITS = qvr_pkg::QuatFracBits
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  qvr_pkg::request_t req,
  output logic              done,
  output qvr_pkg::result_t  result
);
  import qvr_pkg::*;

  localparam int QW      = QuatWidth + 1;          // conjugated component, holds +2^15
  localparam int PW      = 2 * QW;                 // quaternion product
  localparam int CoefW   = PW + 1;                 // matrix term with factor two
  localparam int ProdW   = CoefW + VectorWidth;    // term times component
  localparam int Shift   = 2 * QUAT_FRAC_BITS;
  localparam int AccW    = (Shift + 2 > ProdW + 2) ? Shift + 2 : ProdW + 2;

  localparam logic signed [AccW-1:0] RoundBias = AccW'(1) <<< (Shift - 1);
  localparam logic signed [AccW-1:0] SatMax    = AccW'((64'sd1 <<< (VectorWidth - 1)) - 1);
  localparam logic signed [AccW-1:0] SatMin    = -SatMax - AccW'(1);

  logic [6:1] valid;

  // stage 1: conjugate and widen the quaternion
  logic signed [QW-1:0]          s1_r, s1_i, s1_j, s1_k;
  logic signed [VectorWidth-1:0] s1_vec [3];
  // stage 2: the ten quaternion products
  logic signed [PW-1:0] s2_rr, s2_ii, s2_jj, s2_kk, s2_ij, s2_rk, s2_ik, s2_rj, s2_jk, s2_ri;
  logic signed [VectorWidth-1:0] s2_vec [3];
  // stage 3: rotation matrix terms
  logic signed [CoefW-1:0]       s3_coef [3][3];
  logic signed [VectorWidth-1:0] s3_vec [3];
  // stage 4: term times component
  logic signed [ProdW-1:0]       s4_prod [3][3];
  // stage 5: rounded row sums
  logic signed [AccW-1:0]        s5_acc [3];
  // stage 6 is the output register
  logic signed [VectorWidth-1:0] s6_rot [3];
  logic                          s6_sat;

  logic signed [AccW-1:0]        shifted [3];
  logic [2:0]                    clip;
  logic signed [VectorWidth-1:0] rot_next [3];

  logic signed [QW-1:0] ext_i, ext_j, ext_k;

  assign busy = 1'b0;

  // valid bits move with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[5:1], start & ~busy};
    end
  end

  // sign-extend the vector part for the conjugate select
  always_comb begin
    ext_i = QW'(req.quat_i);
    ext_j = QW'(req.quat_j);
    ext_k = QW'(req.quat_k);
  end

  always_ff @(posedge clk) begin
    s1_r      <= QW'(req.quat_r);
    s1_i      <= req.kind ? -ext_i : ext_i;
    s1_j      <= req.kind ? -ext_j : ext_j;
    s1_k      <= req.kind ? -ext_k : ext_k;
    s1_vec[0] <= req.vec_x;
    s1_vec[1] <= req.vec_y;
    s1_vec[2] <= req.vec_z;
  end

  // quaternion products
  always_ff @(posedge clk) begin
    s2_rr  <= s1_r * s1_r;
    s2_ii  <= s1_i * s1_i;
    s2_jj  <= s1_j * s1_j;
    s2_kk  <= s1_k * s1_k;
    s2_ij  <= s1_i * s1_j;
    s2_rk  <= s1_r * s1_k;
    s2_ik  <= s1_i * s1_k;
    s2_rj  <= s1_r * s1_j;
    s2_jk  <= s1_j * s1_k;
    s2_ri  <= s1_r * s1_i;
    s2_vec <= s1_vec;
  end

  // expanded rotation matrix
  always_ff @(posedge clk) begin
    s3_coef[0][0] <= CoefW'(s2_rr) + CoefW'(s2_ii) - CoefW'(s2_jj) - CoefW'(s2_kk);
    s3_coef[0][1] <= (CoefW'(s2_ij) - CoefW'(s2_rk)) <<< 1;
    s3_coef[0][2] <= (CoefW'(s2_ik) + CoefW'(s2_rj)) <<< 1;
    s3_coef[1][0] <= (CoefW'(s2_ij) + CoefW'(s2_rk)) <<< 1;
    s3_coef[1][1] <= CoefW'(s2_rr) - CoefW'(s2_ii) + CoefW'(s2_jj) - CoefW'(s2_kk);
    s3_coef[1][2] <= (CoefW'(s2_jk) - CoefW'(s2_ri)) <<< 1;
    s3_coef[2][0] <= (CoefW'(s2_ik) - CoefW'(s2_rj)) <<< 1;
    s3_coef[2][1] <= (CoefW'(s2_jk) + CoefW'(s2_ri)) <<< 1;
    s3_coef[2][2] <= CoefW'(s2_rr) - CoefW'(s2_ii) - CoefW'(s2_jj) + CoefW'(s2_kk);
    s3_vec        <= s2_vec;
  end

  // matrix-vector products, one multiplier per term
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        s4_prod[r][c] <= s3_coef[r][c] * s3_vec[c];
      end
    end
  end

  // row sums with round half up
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      s5_acc[r] <= AccW'(s4_prod[r][0]) + AccW'(s4_prod[r][1]) + AccW'(s4_prod[r][2])
                   + RoundBias;
    end
  end

  // drop fraction bits and clip to the vector range
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      shifted[r] = s5_acc[r] >>> Shift;
      clip[r]    = 1'b0;
      if (shifted[r] > SatMax) begin
        rot_next[r] = VectorWidth'(SatMax);
        clip[r]     = 1'b1;
      end else if (shifted[r] < SatMin) begin
        rot_next[r] = VectorWidth'(SatMin);
        clip[r]     = 1'b1;
      end else begin
        rot_next[r] = VectorWidth'(shifted[r]);
      end
    end
  end

  always_ff @(posedge clk) begin
    s6_rot <= rot_next;
    s6_sat <= |clip;
  end

  // result ports
  assign done             = valid[6];
  assign result.rot_x     = s6_rot[0];
  assign result.rot_y     = s6_rot[1];
  assign result.rot_z     = s6_rot[2];
  assign result.saturated = s6_sat;

endmodule

FILE: test/qvr_checker.sv
// qvr_checker: watches the request and result channels of the quaternion rotator,
// predicts each rotated vector and compares it with what the block returns
// depends on qvr_pkg for the payload structs and fixed-point formats
`timescale 1ns / 1ps

module qvr_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  qvr_pkg::request_t req,
  input  logic              done,
  input  qvr_pkg::result_t  result,
  output int                fail_count,
  output int                pending,
  output int                checked,
  output int                sat_count
);
  import qvr_pkg::*;

  localparam int  FracShift = 2 * QuatFracBits;
  localparam longint VecMax = (longint'(1) <<< (VectorWidth - 1)) - 1;
  localparam longint VecMin = -VecMax - 1;

  result_t expected_rotations[$];
  int      n_fail = 0;
  int      n_checked = 0;
  int      n_sat = 0;

  // round half up from Q(2F) to an integer, then clip to the vector range
  function automatic logic signed [VectorWidth-1:0] round_clip(input longint acc,
                                                               output logic clipped);
    longint val;
    val = (acc + (longint'(1) <<< (FracShift - 1))) >>> FracShift;
    clipped = 1'b0;
    if (val > VecMax) begin
      val = VecMax;
      clipped = 1'b1;
    end
    if (val < VecMin) begin
      val = VecMin;
      clipped = 1'b1;
    end
    return val[VectorWidth-1:0];
  endfunction

  // expanded rotation matrix times the vector, exact until the final rounding
  function automatic result_t predict_rotation(input request_t r);
    longint  x, y, z, qr, qi, qj, qk;
    longint  rr, ii, jj, kk;
    logic    c0, c1, c2;
    result_t res;
    x  = $signed(r.vec_x);
    y  = $signed(r.vec_y);
    z  = $signed(r.vec_z);
    qr = $signed(r.quat_r);
    qi = $signed(r.quat_i);
    qj = $signed(r.quat_j);
    qk = $signed(r.quat_k);
    // conjugate: the most negative component becomes +2^15, no wrap
    if (r.kind) begin
      qi = -qi;
      qj = -qj;
      qk = -qk;
    end
    rr = qr * qr;
    ii = qi * qi;
    jj = qj * qj;
    kk = qk * qk;
    res.rot_x = round_clip((rr + ii - jj - kk) * x + 2 * (qi * qj - qr * qk) * y
                           + 2 * (qi * qk + qr * qj) * z, c0);
    res.rot_y = round_clip(2 * (qi * qj + qr * qk) * x + (rr - ii + jj - kk) * y
                           + 2 * (qj * qk - qr * qi) * z, c1);
    res.rot_z = round_clip(2 * (qi * qk - qr * qj) * x + 2 * (qj * qk + qr * qi) * y
                           + (rr - ii - jj + kk) * z, c2);
    res.saturated = c0 | c1 | c2;
    return res;
  endfunction

  // compare results first, then queue the prediction for a new request
  always @(posedge clk) begin
    result_t exp_res;
    if (rst) begin
      expected_rotations.delete();
    end else begin
      if (done) begin
        if (expected_rotations.size() == 0) begin
          $error("result with no request outstanding: rot_x %0d rot_y %0d rot_z %0d",
                 result.rot_x, result.rot_y, result.rot_z);
          n_fail++;
        end else begin
          exp_res = expected_rotations.pop_front();
          n_checked++;
          if (exp_res.saturated) n_sat++;
          if (result.rot_x !== exp_res.rot_x) begin
            $error("rot_x expected %0d actual %0d", exp_res.rot_x, result.rot_x);
            n_fail++;
          end
          if (result.rot_y !== exp_res.rot_y) begin
            $error("rot_y expected %0d actual %0d", exp_res.rot_y, result.rot_y);
            n_fail++;
          end
          if (result.rot_z !== exp_res.rot_z) begin
            $error("rot_z expected %0d actual %0d", exp_res.rot_z, result.rot_z);
            n_fail++;
          end
          if (result.saturated !== exp_res.saturated) begin
            $error("saturated expected %0b actual %0b", exp_res.saturated,
                   result.saturated);
            n_fail++;
          end
        end
      end
      if (start && !busy) begin
        expected_rotations.push_back(predict_rotation(req));
      end
    end
    fail_count <= n_fail;
    pending    <= expected_rotations.size();
    checked    <= n_checked;
    sat_count  <= n_sat;
  end

endmodule

FILE: test/tb_quaternion_vector_rotate_top.sv
// tb_quaternion_vector_rotate_top: drives rotation requests into the rotator
// and reports the verdict; checking is done by qvr_checker
// depends on qvr_pkg, qvr_checker and quaternion_vector_rotate_top
`timescale 1ns / 1ps

module tb_quaternion_vector_rotate_top;
  import qvr_pkg::*;

  localparam int NumRandom  = 550;
  localparam int StallLimit = 1000;
  localparam int DrainWait  = 12;
  // Q1.14 constants: one, and cos(45 deg) for quarter turns
  localparam logic [15:0] QOne  = 16'sd16384;
  localparam logic [15:0] QHalf = 16'sd11585;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  request_t req;
  logic     done;
  result_t  result;
  int       fail_count;
  int       pending;
  int       checked;
  int       sat_count;
  int       n_sent;
  int       n_conj;
  int       stall_cycles;
  bit       steady;

  quaternion_vector_rotate_top DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
  );

  qvr_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .done       (done),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .sat_count  (sat_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog on cycles where neither channel moves
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("quaternion_vector_rotate_top verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic request_t make_req(input logic k, input logic [15:0] x, y, z,
                                        input logic [15:0] qr, qi, qj, qk);
    request_t r;
    r.kind   = k;
    r.vec_x  = x;
    r.vec_y  = y;
    r.vec_z  = z;
    r.quat_r = qr;
    r.quat_i = qi;
    r.quat_j = qj;
    r.quat_k = qk;
    return r;
  endfunction

  // boundary values of a 16-bit field, including Q1.14 plus and minus one
  function automatic logic [15:0] corner16();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h8001;
      2: return 16'hFFFF;
      3: return 16'h0000;
      4: return 16'h0001;
      5: return 16'h7FFF;
      6: return 16'h4000;
      default: return 16'hC000;
    endcase
  endfunction

  // random unit quaternion scaled to Q1.14
  function automatic request_t unit_rotation();
    int  a[4];
    real n;
    request_t r;
    foreach (a[m]) a[m] = int'($urandom_range(0, 65535)) - 32768;
    n = $sqrt(real'(a[0]) * a[0] + real'(a[1]) * a[1] + real'(a[2]) * a[2]
              + real'(a[3]) * a[3]);
    r = make_req(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), 16'($urandom),
                 QOne, 16'h0000, 16'h0000, 16'h0000);
    if (n >= 1.0) begin
      r.quat_r = 16'($rtoi(a[0] * 16384.0 / n));
      r.quat_i = 16'($rtoi(a[1] * 16384.0 / n));
      r.quat_j = 16'($rtoi(a[2] * 16384.0 / n));
      r.quat_k = 16'($rtoi(a[3] * 16384.0 / n));
    end
    return r;
  endfunction

  // one request: random idle cycles first unless steady, then hold it until taken
  task automatic send_request(input request_t r);
    while (!steady && $urandom_range(0, 99) < 14) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    n_sent++;
    if (r.kind) n_conj++;
  endtask

  // stimulus
  initial begin
    request_t r;
    int       sel;
    rst    <= 1'b1;
    start  <= 1'b0;
    req    <= '0;
    steady = 1'b0;
    n_sent = 0;
    n_conj = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity rotation, small values and the vector extremes, both directions
    send_request(make_req(1'b0, 16'd1, 16'd2, 16'd3, QOne, 16'h0, 16'h0, 16'h0));
    send_request(make_req(1'b1, 16'h7FFF, 16'h8000, 16'h0, QOne, 16'h0, 16'h0, 16'h0));
    send_request(make_req(1'b0, 16'h8000, 16'h8000, 16'h8000, QOne, 16'h0, 16'h0,
                          16'h0));
    // quarter turns about each axis, forward and inverse about k
    send_request(make_req(1'b0, 16'd1000, 16'd0, 16'd0, QHalf, 16'h0, 16'h0, QHalf));
    send_request(make_req(1'b1, 16'd1000, 16'd0, 16'd0, QHalf, 16'h0, 16'h0, QHalf));
    send_request(make_req(1'b0, 16'd0, 16'd1000, 16'd0, QHalf, QHalf, 16'h0, 16'h0));
    send_request(make_req(1'b1, 16'd0, 16'd0, 16'd1000, QHalf, 16'h0, QHalf, 16'h0));
    // half turn about i
    send_request(make_req(1'b0, 16'd123, -16'sd456, 16'd789, 16'h0, QOne, 16'h0,
                          16'h0));
    // zero quaternion collapses the vector
    send_request(make_req(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0, 16'h0, 16'h0,
                          16'h0));
    // non-unit quaternion scales by a quarter: rounding of halves and quarters
    send_request(make_req(1'b0, 16'd5, -16'sd7, 16'h7FFF, 16'sd8192, 16'h0, 16'h0,
                          16'h0));
    send_request(make_req(1'b1, 16'd2, -16'sd2, 16'd6, 16'sd8192, 16'h0, 16'h0, 16'h0));
    // most negative components, forward and conjugated
    send_request(make_req(1'b0, 16'd1, 16'd1, 16'd1, 16'h8000, 16'h8000, 16'h8000,
                          16'h8000));
    send_request(make_req(1'b1, 16'd1, 16'd1, 16'd1, 16'h8000, 16'h8000, 16'h8000,
                          16'h8000));
    send_request(make_req(1'b1, 16'd100, 16'd200, 16'd300, 16'h8000, 16'h0, 16'h0,
                          16'h0));
    send_request(make_req(1'b1, -16'sd1, 16'd2, -16'sd3, 16'h0, 16'h8000, 16'h0,
                          16'h0));
    // overflow in both directions
    send_request(make_req(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                          16'h7FFF, 16'h7FFF));
    send_request(make_req(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                          16'h7FFF, 16'h7FFF));
    send_request(make_req(1'b0, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h0, 16'h0,
                          16'h0));
    send_request(make_req(1'b0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0, 16'h0, 16'h7FFF,
                          16'h8000));
    // zero vector
    send_request(make_req(1'b1, 16'h0, 16'h0, 16'h0, 16'h1234, 16'hABCD, 16'h7FFF,
                          16'h8000));

    // random part: mostly unit rotations, the rest raw fields and corners
    for (int n = 0; n < NumRandom; n++) begin
      steady = (n >= 250 && n < 380);
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        r = unit_rotation();
      end else if (sel < 85) begin
        r = make_req(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
      end else begin
        r = make_req(1'($urandom_range(0, 1)), corner16(), corner16(), corner16(),
                     corner16(), corner16(), corner16(), corner16());
      end
      send_request(r);
    end
    start <= 1'b0;

    // drain, then give a stray result time to show up
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("sent %0d requests (%0d by the conjugate), checked %0d results, %0d saturated",
             n_sent, n_conj, checked, sat_count);
    if (pending != 0) $error("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("quaternion_vector_rotate_top verification clean");
    end else begin
      $display("quaternion_vector_rotate_top verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/qvr_pkg.sv
hw/rtl/quaternion_vector_rotate_top.sv
test/qvr_checker.sv
test/tb_quaternion_vector_rotate_top.sv
